// ----- rtl/sot_pkg.sv -----
// Package for the script opcode tokenizer: parse phases, byte roles,
// opcode constants, register indexes and the minimal-push check.
// No dependencies; script_op_tokenizer imports it.
`default_nettype none

package sot_pkg;

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    localparam logic [1:0] ROLE_OPCODE = 2'd0;
    localparam logic [1:0] ROLE_LENGTH = 2'd1;
    localparam logic [1:0] ROLE_DATA   = 2'd2;

    localparam logic CFG_OP_CEIL          = 1'b0;
    localparam logic CFG_MAX_ELEMENT_SIZE = 1'b1;

    localparam logic [7:0]  OP_CEIL_RESET          = 8'd185;
    localparam logic [31:0] MAX_ELEMENT_SIZE_RESET = 32'd520;

    localparam logic [7:0] OP_0           = 8'h00;
    localparam logic [7:0] OP_LEN8        = 8'h4c;
    localparam logic [7:0] OP_LEN16       = 8'h4d;
    localparam logic [7:0] OP_LEN32       = 8'h4e;
    localparam logic [7:0] OP_PUSH_ONLY_MAX = 8'h60;
    localparam logic [7:0] NEG_ONE_BYTE   = 8'h81;
    localparam logic [7:0] SMALL_NUM_MAX  = 8'd16;

    localparam logic [31:0] DIRECT_PUSH_MAX = 32'd75;
    localparam logic [31:0] PUSHDATA1_MAX   = 32'd255;
    localparam logic [31:0] PUSHDATA2_MAX   = 32'd65535;

    typedef struct packed {
        logic [1:0]  byte_role;
        logic        op_done;
        logic [7:0]  opcode;
        logic [31:0] push_length;
        logic        minimal_push;
        logic        script_end;
        logic        parse_ok;
        logic        ops_valid;
        logic        push_only;
    } result_t;

    // A push is minimal when no shorter encoding of the same data exists.
    function automatic logic is_minimal(input logic [7:0]  op,
                                        input logic [31:0] size,
                                        input logic [7:0]  d0);
        logic r;
        begin
            if (size == 32'd0)
                r = (op == OP_0);
            else if (size == 32'd1 && d0 >= 8'd1 && d0 <= SMALL_NUM_MAX)
                r = 1'b0;
            else if (size == 32'd1 && d0 == NEG_ONE_BYTE)
                r = 1'b0;
            else if (size <= DIRECT_PUSH_MAX)
                r = (op == size[7:0]);
            else if (size <= PUSHDATA1_MAX)
                r = (op == OP_LEN8);
            else if (size <= PUSHDATA2_MAX)
                r = (op == OP_LEN16);
            else
                r = 1'b1;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sot_if.sv -----
// Valid/ready channel interfaces of the script opcode tokenizer:
// one for script bytes in, one for per-byte results out. No dependencies.
`default_nettype none

interface sot_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;

    modport source (output valid, output byte_value, output last_byte, input ready);
    modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface sot_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  byte_role;
    logic        op_done;
    logic [7:0]  opcode;
    logic [31:0] push_length;
    logic        minimal_push;
    logic        script_end;
    logic        parse_ok;
    logic        ops_valid;
    logic        push_only;

    modport source (output valid, output byte_role, output op_done, output opcode,
                    output push_length, output minimal_push, output script_end,
                    output parse_ok, output ops_valid, output push_only,
                    input ready);
    modport sink   (input valid, input byte_role, input op_done, input opcode,
                    input push_length, input minimal_push, input script_end,
                    input parse_ok, input ops_valid, input push_only,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/script_op_tokenizer.sv -----
// Script opcode tokenizer: one script byte in per cycle while not stalled, one result
// out per byte. The result reaches the result register in the cycle after its byte is
// taken; throughput, one byte per cycle while not stalled, is set by the single
// parse-state update between the input and the result register. A new byte is taken
// while the result register is empty or being drained. Reset clears the parse state
// and restores the opcode ceiling to 185 and max_element_size to 520. Depends on sot_pkg and sot_if.
`default_nettype none

module script_op_tokenizer
    import sot_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data,
    sot_in_if.sink           script_byte,
    sot_out_if.source        result
);

    logic [7:0]  op_ceil_reg;
    logic [31:0] max_element_size_reg;

    phase_t      phase_reg, phase_next;
    logic [7:0]  current_op_reg, current_op_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [1:0]  len_idx_reg, len_idx_next;
    logic [31:0] push_size_reg, push_size_next;
    logic [31:0] data_left_reg, data_left_next;
    logic        ops_invalid_reg, ops_invalid_next;
    logic        not_push_only_reg, not_push_only_next;

    logic        out_valid_reg;
    result_t     res_reg, res_next;

    logic        in_fire;
    logic        push_done;
    logic        parse_ok;
    logic [7:0]  b;

    assign b                 = script_byte.byte_value;
    assign script_byte.ready = !out_valid_reg || result.ready;
    assign in_fire           = script_byte.valid && script_byte.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_ceil_reg          <= OP_CEIL_RESET;
            max_element_size_reg <= MAX_ELEMENT_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_OP_CEIL:          op_ceil_reg          <= cfg_data[7:0];
                CFG_MAX_ELEMENT_SIZE: max_element_size_reg <= cfg_data;
                default:              op_ceil_reg          <= op_ceil_reg;
            endcase
        end
    end

    // Parse step for the byte on the input.
    always_comb
    begin
        phase_next         = phase_reg;
        current_op_next    = current_op_reg;
        len_left_next      = len_left_reg;
        len_idx_next       = len_idx_reg;
        push_size_next     = push_size_reg;
        data_left_next     = data_left_reg;
        ops_invalid_next   = ops_invalid_reg;
        not_push_only_next = not_push_only_reg;
        push_done          = 1'b0;
        res_next           = '0;

        case (phase_reg)
            PH_OPCODE:
            begin
                res_next.byte_role = ROLE_OPCODE;
                current_op_next    = b;
                if (b > op_ceil_reg)
                    ops_invalid_next = 1'b1;
                if (b > OP_PUSH_ONLY_MAX)
                    not_push_only_next = 1'b1;
                if (b == OP_0)
                begin
                    push_size_next = '0;
                    push_done      = 1'b1;
                end
                else if (b < OP_LEN8)
                begin
                    push_size_next = {24'd0, b};
                    data_left_next = {24'd0, b};
                    phase_next     = PH_DATA;
                end
                else if (b <= OP_LEN32)
                begin
                    push_size_next = '0;
                    len_idx_next   = 2'd0;
                    if (b == OP_LEN8)
                        len_left_next = 3'd1;
                    else if (b == OP_LEN16)
                        len_left_next = 3'd2;
                    else
                        len_left_next = 3'd4;
                    phase_next = PH_LENGTH;
                end
                else
                begin
                    res_next.op_done      = 1'b1;
                    res_next.opcode       = b;
                    res_next.minimal_push = 1'b1;
                end
            end
            PH_LENGTH:
            begin
                // Length bytes arrive least significant first.
                res_next.byte_role = ROLE_LENGTH;
                push_size_next = push_size_reg | ({24'd0, b} << {len_idx_reg, 3'b000});
                len_idx_next   = len_idx_reg + 2'd1;
                len_left_next  = len_left_reg - 3'd1;
                if (len_left_next == 3'd0)
                begin
                    if (push_size_next == 32'd0)
                        push_done = 1'b1;
                    else
                    begin
                        data_left_next = push_size_next;
                        phase_next     = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                res_next.byte_role = ROLE_DATA;
                data_left_next     = data_left_reg - 32'd1;
                if (data_left_next == 32'd0)
                    push_done = 1'b1;
            end
            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase

        // A one-byte push finishes on its only data byte, so the byte on the
        // input is the first data byte whenever the size check needs it.
        if (push_done)
        begin
            res_next.op_done      = 1'b1;
            res_next.opcode       = current_op_next;
            res_next.push_length  = push_size_next;
            res_next.minimal_push = is_minimal(current_op_next, push_size_next, b);
            if (push_size_next > max_element_size_reg)
                ops_invalid_next = 1'b1;
            phase_next = PH_OPCODE;
        end

        parse_ok            = (phase_next == PH_OPCODE);
        res_next.script_end = script_byte.last_byte;

        if (script_byte.last_byte)
        begin
            res_next.parse_ok  = parse_ok;
            res_next.ops_valid = parse_ok && !ops_invalid_next;
            res_next.push_only = parse_ok && !not_push_only_next;
            phase_next         = PH_OPCODE;
            current_op_next    = '0;
            len_left_next      = '0;
            len_idx_next       = '0;
            push_size_next     = '0;
            data_left_next     = '0;
            ops_invalid_next   = 1'b0;
            not_push_only_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_OPCODE;
            current_op_reg    <= '0;
            len_left_reg      <= '0;
            len_idx_reg       <= '0;
            push_size_reg     <= '0;
            data_left_reg     <= '0;
            ops_invalid_reg   <= 1'b0;
            not_push_only_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            current_op_reg    <= current_op_next;
            len_left_reg      <= len_left_next;
            len_idx_reg       <= len_idx_next;
            push_size_reg     <= push_size_next;
            data_left_reg     <= data_left_next;
            ops_invalid_reg   <= ops_invalid_next;
            not_push_only_reg <= not_push_only_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.byte_role    = res_reg.byte_role;
    assign result.op_done      = res_reg.op_done;
    assign result.opcode       = res_reg.opcode;
    assign result.push_length  = res_reg.push_length;
    assign result.minimal_push = res_reg.minimal_push;
    assign result.script_end   = res_reg.script_end;
    assign result.parse_ok     = res_reg.parse_ok;
    assign result.ops_valid    = res_reg.ops_valid;
    assign result.push_only    = res_reg.push_only;

endmodule

`default_nettype wire
